// ===== design/csvp_pkg.sv =====
// csvp_pkg: shared types and constants for the csv line and field parser
// used by csvp_step, csv_line_field_parser_top and csvp_checker
package csvp_pkg;

  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] SEP_RESET  = 8'd44;

  typedef enum logic [1:0] {
    EV_CHAR      = 2'd0,
    EV_FIELD_END = 2'd1,
    EV_LINE_END  = 2'd2
  } event_kind_e;

  typedef struct packed {
    logic inside_quotes;
    logic quote_waiting;
    logic field_nonempty;
  } parse_state_t;

  typedef struct packed {
    logic        emit;
    event_kind_e kind;
    logic [7:0]  char_out;
    logic        final_field_kept;
  } parse_event_t;

endpackage

// ===== design/csvp_step.sv =====
// csvp_step: per-byte decode of the csv parser flags and the resulting event
// depends on csvp_pkg
module csvp_step (
  input  logic [7:0]             in_byte_i,
  input  logic                   stream_end_i,
  input  logic [7:0]             field_separator_i,
  input  csvp_pkg::parse_state_t state_i,
  output csvp_pkg::parse_state_t state_o,
  output csvp_pkg::parse_event_t event_o
);

  logic is_quote;
  logic is_newline;
  logic lit_quote;
  logic in_q;

  assign is_quote   = (in_byte_i == csvp_pkg::CH_QUOTE);
  assign is_newline = (in_byte_i == csvp_pkg::CH_NEWLINE);
  assign lit_quote  = state_i.quote_waiting && !stream_end_i && is_quote;
  // a waiting quote not followed by a quote closes the section
  assign in_q       = state_i.inside_quotes && !state_i.quote_waiting;

  always_comb begin
    state_o                  = state_i;
    state_o.quote_waiting    = 1'b0;
    state_o.inside_quotes    = in_q;
    event_o.emit             = 1'b0;
    event_o.kind             = csvp_pkg::EV_CHAR;
    event_o.char_out         = 8'd0;
    event_o.final_field_kept = 1'b0;
    if (lit_quote) begin
      state_o.inside_quotes  = 1'b1;
      state_o.field_nonempty = 1'b1;
      event_o.emit           = 1'b1;
      event_o.char_out       = csvp_pkg::CH_QUOTE;
    end else if (!stream_end_i && is_newline && in_q) begin
      state_o.field_nonempty = 1'b1;
      event_o.emit           = 1'b1;
      event_o.char_out       = in_byte_i;
    end else if (stream_end_i || is_newline) begin
      state_o                  = '0;
      event_o.emit             = 1'b1;
      event_o.kind             = csvp_pkg::EV_LINE_END;
      event_o.final_field_kept = state_i.field_nonempty;
    end else if ((in_byte_i == field_separator_i) && !in_q) begin
      state_o.field_nonempty = 1'b0;
      event_o.emit           = 1'b1;
      event_o.kind           = csvp_pkg::EV_FIELD_END;
    end else if (is_quote) begin
      if (in_q) begin
        state_o.quote_waiting = 1'b1;
      end else begin
        state_o.inside_quotes = 1'b1;
      end
    end else if (in_byte_i == csvp_pkg::CH_CR) begin
      state_o.field_nonempty = state_i.field_nonempty;
    end else begin
      state_o.field_nonempty = 1'b1;
      event_o.emit           = 1'b1;
      event_o.char_out       = in_byte_i;
    end
  end

endmodule

// ===== design/csv_line_field_parser_top.sv =====
// csv_line_field_parser_top: splits a csv byte stream into characters, field and line ends
// depends on csvp_pkg and csvp_step
// the result is registered on the output register in the cycle after the input transaction
// throughput: one byte per cycle while the output is not stalled, set by the single output register stage
// reset clears the quote and field flags and the output valid; separator resets to 44
module csv_line_field_parser_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_data_i,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] in_byte
  input  logic       s_axis_tlast_i,   // stream_end
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] char_out
  output logic [2:0] m_axis_tuser_o    // [1:0] event_kind, [2] final_field_kept
);

  logic [7:0]             sep_q;
  csvp_pkg::parse_state_t state_q, state_d;
  csvp_pkg::parse_event_t ev;
  logic                   out_valid_q, out_valid_d;
  logic [7:0]             out_data_q;
  logic [2:0]             out_user_q;
  logic                   in_fire;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  csvp_step u_step (
    .in_byte_i         (s_axis_tdata_i),
    .stream_end_i      (s_axis_tlast_i),
    .field_separator_i (sep_q),
    .state_i           (state_q),
    .state_o           (state_d),
    .event_o           (ev)
  );

  always_comb begin
    out_valid_d = out_valid_q && !m_axis_tready_i;
    if (in_fire) begin
      out_valid_d = ev.emit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sep_q       <= csvp_pkg::SEP_RESET;
      state_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        sep_q <= cfg_data_i;
      end
      if (in_fire) begin
        state_q <= state_d;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && ev.emit) begin
      out_data_q <= ev.char_out;
      out_user_q <= {ev.final_field_kept, ev.kind};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

endmodule

// ===== design/csvp_checker.sv =====
// csvp_checker: port-level assertions for csv_line_field_parser_top
// depends on csvp_pkg; bound to the top level below
module csvp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid_i,
  input logic       s_axis_tready_o,
  input logic       s_axis_tlast_i,
  input logic       m_axis_tvalid_o,
  input logic       m_axis_tready_i,
  input logic [7:0] m_axis_tdata_o,
  input logic [2:0] m_axis_tuser_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("output changed while stalled");

  // end of input always closes the line in the next cycle
  a_end_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && s_axis_tlast_i |=>
      m_axis_tvalid_o && (m_axis_tuser_o[1:0] == csvp_pkg::EV_LINE_END))
    else $error("end of input without line end");

  // only character events carry data
  a_char_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o[1:0] != csvp_pkg::EV_CHAR) |->
      m_axis_tdata_o == 8'd0)
    else $error("nonzero data on non-character event");

  // kept flag only on line ends
  a_kept_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[2] |->
      m_axis_tuser_o[1:0] == csvp_pkg::EV_LINE_END)
    else $error("kept flag outside line end");

endmodule

bind csv_line_field_parser_top csvp_checker u_csvp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tlast_i  (s_axis_tlast_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
